// ===== src/stage_latency_statistics_top_assert.svh =====
// Assertion macros shared by the stage latency statistics RTL.
`ifndef STAGE_LATENCY_STATISTICS_TOP_ASSERT_SVH
`define STAGE_LATENCY_STATISTICS_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define SLT_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("stage latency statistics: assertion failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define SLT_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("stage latency statistics: assertion failed");

`endif

// ===== src/slt_pkg.sv =====
// Types, constants and helpers for the stage latency statistics block.
package slt_pkg;

    localparam int MAX_STAGES = 16;
    localparam int SLOT_W     = $clog2(MAX_STAGES);
    localparam int CNT_W      = $clog2(MAX_STAGES + 1);

    localparam int ID_W    = 16;
    localparam int TS_W    = 48;
    localparam int LAT_W   = 32;
    localparam int SUM_W   = 48;
    localparam int SQ_W    = 64;
    localparam int COUNT_W = 32;
    localparam int ITER_W  = 32;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 288;

    // Item kinds
    localparam logic [1:0] KIND_MARK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_WAIT   = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_UNUSED = 2'd3;

    typedef struct packed {
        logic [LAT_W-1:0]   min_lat;
        logic [LAT_W-1:0]   max_lat;
        logic [SUM_W-1:0]   sum;
        logic [SQ_W-1:0]    sq_sum;
        logic [COUNT_W-1:0] count;
    } stat_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } match_t;

    function automatic logic [SLOT_W-1:0] rs_to_slot(logic [3:0] rs);
        logic [SLOT_W+3:0] w;
        w = {{SLOT_W{1'b0}}, rs};
        return w[SLOT_W-1:0];
    endfunction

    function automatic logic [3:0] slot_to_field(logic [SLOT_W-1:0] idx);
        logic [SLOT_W+3:0] w;
        w = {4'b0, idx};
        return w[3:0];
    endfunction

    function automatic logic [4:0] used_to_field(logic [CNT_W-1:0] c);
        logic [CNT_W+4:0] w;
        w = {5'b0, c};
        return w[4:0];
    endfunction

endpackage

// ===== src/slt_slot_match.sv =====
// Stage identifier table with parallel lookup of the marked identifier.
module slt_slot_match (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [slt_pkg::SLOT_W-1:0] wr_slot,
    input  logic [slt_pkg::ID_W-1:0]   wr_id,
    input  logic [slt_pkg::ID_W-1:0]   look_id,
    input  logic [slt_pkg::CNT_W-1:0]  slots_used,
    output slt_pkg::match_t            result
);
    import slt_pkg::*;

    logic [ID_W-1:0] id_reg [MAX_STAGES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            id_reg[wr_slot] <= wr_id;
        end
    end

    // Lowest matching slot wins; entries at or above slots_used are ignored.
    always_comb begin
        result = '0;
        for (int i = MAX_STAGES - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < slots_used) && (id_reg[i] == look_id)) begin
                result.hit = 1'b1;
                result.idx = SLOT_W'(i);
            end
        end
    end

endmodule

// ===== src/slt_accum.sv =====
// Latency measurement and saturating statistics update for one slot.
module slt_accum (
    input  logic [slt_pkg::TS_W-1:0]  ts,
    input  logic [slt_pkg::TS_W-1:0]  ref_mark,
    input  slt_pkg::stat_t            old_stat,
    output logic [slt_pkg::LAT_W-1:0] lat,
    output slt_pkg::stat_t            new_stat
);
    import slt_pkg::*;

    logic [TS_W-1:0]  diff;
    logic [SUM_W:0]   sum_ext;
    logic [SQ_W-1:0]  sq;
    logic [SQ_W:0]    sq_ext;
    logic             empty;

    always_comb begin
        diff    = ts - ref_mark;
        lat     = (|diff[TS_W-1:LAT_W]) ? '1 : diff[LAT_W-1:0];
        sum_ext = {1'b0, old_stat.sum} + (SUM_W + 1)'(lat);
        sq      = SQ_W'(lat) * SQ_W'(lat);
        sq_ext  = {1'b0, old_stat.sq_sum} + {1'b0, sq};
        empty   = (old_stat.count == '0);

        new_stat.sum    = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        new_stat.sq_sum = sq_ext[SQ_W] ? '1 : sq_ext[SQ_W-1:0];
        new_stat.min_lat = (empty || lat < old_stat.min_lat) ? lat : old_stat.min_lat;
        new_stat.max_lat = (empty || lat > old_stat.max_lat) ? lat : old_stat.max_lat;
        new_stat.count  = (&old_stat.count) ? old_stat.count
                                            : old_stat.count + COUNT_W'(1);
    end

endmodule

// ===== src/stage_latency_statistics_top.sv =====
// A word accepted on s_ waits in the input register until its result is registered for m_.
// One word per cycle unless m_ stalls; match, subtract, square and accumulate run in one pass.
// Back-pressure on m_ stalls the input register only when both registers are full.
// Reset clears slot count, start flag, iteration count, stage marks and statistics valid bits.
// Statistics of a slot without a valid bit read as zero; no clearing pass is needed.
`include "stage_latency_statistics_top_assert.svh"

module stage_latency_statistics_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // stage_id [15:0], timestamp_us [63:16], read_slot [67:64], zero [71:68]
    input  logic [slt_pkg::S_TDATA_W-1:0] s_tdata,
    // kind [1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // slot [3:0], last_latency [35:4], min_latency [67:36], max_latency [99:68],
    // latency_sum [147:100], latency_square_sum [211:148], sample_count [243:212],
    // iterations [275:244], stages_in_use [280:276], zero [287:281]
    output logic [slt_pkg::M_TDATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [1:0]                    m_tuser
);
    import slt_pkg::*;

    // Input register
    logic              in_vld_reg;
    logic [1:0]        in_kind_reg;
    logic [ID_W-1:0]   in_id_reg;
    logic [TS_W-1:0]   in_ts_reg;
    logic [3:0]        in_rs_reg;

    // Block state
    logic [CNT_W-1:0]      slots_used_reg, slots_used_next;
    logic                  started_reg, started_next;
    logic [ITER_W-1:0]     iter_reg, iter_next;
    logic [TS_W-1:0]       mark_reg [MAX_STAGES];
    stat_t                 stat_reg [MAX_STAGES];
    logic [MAX_STAGES-1:0] stat_vld_reg;

    // Result register
    logic              m_vld_reg;
    logic [1:0]        out_status_reg, out_status_next;
    logic [3:0]        out_slot_reg, out_slot_next;
    logic [LAT_W-1:0]  out_lat_reg, out_lat_next;
    stat_t             out_stat_reg, out_stat_next;
    logic [ITER_W-1:0] out_iter_reg;
    logic [4:0]        out_used_reg;

    logic              advance;
    match_t            match;
    logic              full;
    logic [SLOT_W-1:0] mark_idx, rs_idx, sel_idx, ref_idx;
    stat_t             old_stat, new_stat;
    logic [LAT_W-1:0]  lat;
    logic              id_wr, mark_wr, stat_wr, clear;
    logic [MAX_STAGES-1:0] used_mask;

    assign advance  = in_vld_reg && (!m_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    slt_slot_match u_match (
        .aclk       (aclk),
        .wr_en      (advance && id_wr),
        .wr_slot    (mark_idx),
        .wr_id      (in_id_reg),
        .look_id    (in_id_reg),
        .slots_used (slots_used_reg),
        .result     (match)
    );

    always_comb begin
        full     = (slots_used_reg == CNT_W'(MAX_STAGES));
        mark_idx = match.hit ? match.idx : slots_used_reg[SLOT_W-1:0];
        rs_idx   = rs_to_slot(in_rs_reg);
        sel_idx  = (in_kind_reg == KIND_MARK) ? mark_idx : rs_idx;
        ref_idx  = (mark_idx == '0) ? '0 : mark_idx - SLOT_W'(1);
        old_stat = stat_vld_reg[sel_idx] ? stat_reg[sel_idx] : '0;
    end

    slt_accum u_accum (
        .ts       (in_ts_reg),
        .ref_mark (mark_reg[ref_idx]),
        .old_stat (old_stat),
        .lat      (lat),
        .new_stat (new_stat)
    );

    always_comb begin
        id_wr           = 1'b0;
        mark_wr         = 1'b0;
        stat_wr         = 1'b0;
        clear           = 1'b0;
        slots_used_next = slots_used_reg;
        started_next    = started_reg;
        iter_next       = iter_reg;
        out_status_next = ST_OK;
        out_slot_next   = '0;
        out_lat_next    = '0;
        out_stat_next   = '0;
        case (in_kind_reg)
            KIND_MARK: begin
                if (!match.hit && full) begin
                    out_status_next = ST_FULL;
                end else begin
                    if (!match.hit) begin
                        id_wr           = 1'b1;
                        slots_used_next = slots_used_reg + CNT_W'(1);
                    end
                    if (mark_idx == '0 && !(&iter_reg)) begin
                        iter_next = iter_reg + ITER_W'(1);
                    end
                    out_slot_next = slot_to_field(mark_idx);
                    if (!started_reg) begin
                        // Before the first loop head register ids; the head keeps its stamp
                        out_stat_next = old_stat;
                        if (mark_idx == '0) begin
                            mark_wr      = 1'b1;
                            started_next = 1'b1;
                        end else begin
                            out_status_next = ST_WAIT;
                        end
                    end else begin
                        mark_wr       = 1'b1;
                        stat_wr       = 1'b1;
                        out_lat_next  = lat;
                        out_stat_next = new_stat;
                    end
                end
            end
            KIND_READ: begin
                out_slot_next = in_rs_reg;
                if ({4'b0, in_rs_reg} >= 8'(slots_used_reg)) begin
                    out_status_next = ST_UNUSED;
                end else begin
                    out_stat_next = old_stat;
                end
            end
            KIND_CLEAR: begin
                clear = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            m_vld_reg      <= 1'b0;
            slots_used_reg <= '0;
            started_reg    <= 1'b0;
            iter_reg       <= '0;
            stat_vld_reg   <= '0;
            for (int i = 0; i < MAX_STAGES; i++) begin
                mark_reg[i] <= '0;
            end
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                m_vld_reg <= 1'b1;
            end else if (m_tready) begin
                m_vld_reg <= 1'b0;
            end
            if (advance) begin
                slots_used_reg <= slots_used_next;
                started_reg    <= started_next;
                iter_reg       <= iter_next;
                if (mark_wr) begin
                    mark_reg[mark_idx] <= in_ts_reg;
                end
                if (clear) begin
                    stat_vld_reg <= '0;
                end else if (stat_wr) begin
                    stat_vld_reg[mark_idx] <= 1'b1;
                end
            end
        end
    end

    // Payload: hold the word until taken, then load the next; results load on advance
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser;
            in_id_reg   <= s_tdata[15:0];
            in_ts_reg   <= s_tdata[63:16];
            in_rs_reg   <= s_tdata[67:64];
        end
        if (advance) begin
            if (stat_wr) begin
                stat_reg[mark_idx] <= new_stat;
            end
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
            out_lat_reg    <= out_lat_next;
            out_stat_reg   <= out_stat_next;
            out_iter_reg   <= iter_next;
            out_used_reg   <= used_to_field(slots_used_next);
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'b0, out_used_reg, out_iter_reg, out_stat_reg.count,
                       out_stat_reg.sq_sum, out_stat_reg.sum, out_stat_reg.max_lat,
                       out_stat_reg.min_lat, out_lat_reg, out_slot_reg};

    always_comb begin
        for (int i = 0; i < MAX_STAGES; i++) begin
            used_mask[i] = (CNT_W'(i) < slots_used_reg);
        end
    end

    `SLT_ASSERT_IMP(a_used_bound, 1'b1, slots_used_reg <= CNT_W'(MAX_STAGES))
    `SLT_ASSERT_NXT(a_started_holds, started_reg, started_reg)
    `SLT_ASSERT_IMP(a_full_only_when_full, m_vld_reg && out_status_reg == ST_FULL, full)
    `SLT_ASSERT_IMP(a_stats_in_used_slots, 1'b1, (stat_vld_reg & ~used_mask) == '0)

endmodule

// ===== bench/tb_stage_latency_statistics_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the stage latency statistics block: loop marks, reads, clears.
module tb_stage_latency_statistics_top;
    import slt_pkg::*;

    localparam logic [1:0] KIND_IGNORED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 1030;
    localparam int QUIET_WORDS    = 150;
    localparam int POOL_SIZE      = 20;
    localparam int SHOWN_ERRORS   = 100;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         slot;
        logic [LAT_W-1:0]   last_lat;
        logic [LAT_W-1:0]   lo_lat;
        logic [LAT_W-1:0]   hi_lat;
        logic [SUM_W-1:0]   lat_total;
        logic [SQ_W-1:0]    sq_total;
        logic [COUNT_W-1:0] samples;
        logic [ITER_W-1:0]  iters;
        logic [4:0]         in_use;
    } stage_report_t;

    class stage_stats_scoreboard;
        logic [ID_W-1:0]    stage_tag [MAX_STAGES];
        int unsigned        tag_count;
        bit                 loop_started;
        logic [TS_W-1:0]    stamp [MAX_STAGES];
        logic [LAT_W-1:0]   fastest [MAX_STAGES];
        logic [LAT_W-1:0]   slowest [MAX_STAGES];
        logic [SUM_W-1:0]   total [MAX_STAGES];
        logic [SQ_W-1:0]    sq_total [MAX_STAGES];
        logic [COUNT_W-1:0] samples [MAX_STAGES];
        logic [ITER_W-1:0]  loop_count;
        stage_report_t      pending_reports [$];
        int                 errors;

        function new();
            foreach (stage_tag[i]) begin
                stage_tag[i] = '0;
                stamp[i] = '0;
            end
            clear_stats();
            tag_count = 0;
            loop_started = 0;
            loop_count = '0;
            errors = 0;
        endfunction

        function void clear_stats();
            foreach (fastest[i]) begin
                fastest[i] = '0;
                slowest[i] = '0;
                total[i] = '0;
                sq_total[i] = '0;
                samples[i] = '0;
            end
        endfunction

        function stage_report_t pack_stats(logic [1:0] status, int unsigned idx,
                                           logic [LAT_W-1:0] lat, bit with_stats);
            stage_report_t r;
            r = '0;
            r.status = status;
            r.slot = idx[3:0];
            r.last_lat = lat;
            if (with_stats) begin
                r.lo_lat = fastest[idx];
                r.hi_lat = slowest[idx];
                r.lat_total = total[idx];
                r.sq_total = sq_total[idx];
                r.samples = samples[idx];
            end
            r.iters = loop_count;
            r.in_use = tag_count[4:0];
            return r;
        endfunction

        function stage_report_t mark_stage(logic [ID_W-1:0] id, logic [TS_W-1:0] ts);
            int unsigned      idx;
            int unsigned      prev;
            logic [TS_W-1:0]  diff;
            logic [LAT_W-1:0] lat;
            logic [SUM_W:0]   sum_next;
            logic [SQ_W:0]    sq_next;
            idx = 0;
            while (idx < tag_count && stage_tag[idx] != id)
                idx++;
            if (idx == tag_count) begin
                if (tag_count >= MAX_STAGES)
                    return pack_stats(ST_FULL, 0, '0, 0);
                stage_tag[idx] = id;
                tag_count++;
            end
            if (idx == 0 && loop_count != '1)
                loop_count++;
            if (!loop_started) begin
                if (idx == 0) begin
                    stamp[0] = ts;
                    loop_started = 1;
                    return pack_stats(ST_OK, 0, '0, 1);
                end
                return pack_stats(ST_WAIT, idx, '0, 1);
            end
            // the loop head measures against itself, others against the slot before
            prev = (idx == 0) ? 0 : idx - 1;
            diff = ts - stamp[prev];
            lat = (diff > 48'hFFFF_FFFF) ? '1 : diff[LAT_W-1:0];
            stamp[idx] = ts;
            sum_next = {1'b0, total[idx]} + lat;
            total[idx] = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
            sq_next = {1'b0, sq_total[idx]} + {33'b0, lat} * {33'b0, lat};
            sq_total[idx] = sq_next[SQ_W] ? '1 : sq_next[SQ_W-1:0];
            if (samples[idx] == 0 || lat < fastest[idx])
                fastest[idx] = lat;
            if (samples[idx] == 0 || lat > slowest[idx])
                slowest[idx] = lat;
            if (samples[idx] != '1)
                samples[idx]++;
            return pack_stats(ST_OK, idx, lat, 1);
        endfunction

        function void note_word(logic [1:0] kind, logic [ID_W-1:0] id, logic [TS_W-1:0] ts,
                                logic [3:0] rs);
            stage_report_t r;
            case (kind)
                KIND_MARK: r = mark_stage(id, ts);
                KIND_READ: r = (rs >= tag_count) ? pack_stats(ST_UNUSED, rs, '0, 0)
                                                 : pack_stats(ST_OK, rs, '0, 1);
                KIND_CLEAR: begin
                    clear_stats();
                    r = pack_stats(ST_OK, 0, '0, 0);
                end
                default: r = pack_stats(ST_OK, 0, '0, 0);
            endcase
            pending_reports = {pending_reports, r};
        endfunction

        task report_mismatch(string what, logic [SQ_W-1:0] got, logic [SQ_W-1:0] want);
            if (errors < SHOWN_ERRORS)
                $display("%0t ns mismatch on %s: got %0h, expected %0h", $time, what, got, want);
            errors++;
        endtask

        task check_word(logic [1:0] status, logic [M_TDATA_W-1:0] data);
            stage_report_t want;
            if (pending_reports.size() == 0) begin
                report_mismatch("result with nothing pending", data[63:0], '0);
                return;
            end
            want = pending_reports.pop_front();
            if (status !== want.status)
                report_mismatch("status", status, want.status);
            if (data[3:0] !== want.slot)
                report_mismatch("slot", data[3:0], want.slot);
            if (data[35:4] !== want.last_lat)
                report_mismatch("last_latency", data[35:4], want.last_lat);
            if (data[67:36] !== want.lo_lat)
                report_mismatch("min_latency", data[67:36], want.lo_lat);
            if (data[99:68] !== want.hi_lat)
                report_mismatch("max_latency", data[99:68], want.hi_lat);
            if (data[147:100] !== want.lat_total)
                report_mismatch("latency_sum", data[147:100], want.lat_total);
            if (data[211:148] !== want.sq_total)
                report_mismatch("latency_square_sum", data[211:148], want.sq_total);
            if (data[243:212] !== want.samples)
                report_mismatch("sample_count", data[243:212], want.samples);
            if (data[275:244] !== want.iters)
                report_mismatch("iterations", data[275:244], want.iters);
            if (data[280:276] !== want.in_use)
                report_mismatch("stages_in_use", data[280:276], want.in_use);
            if (data[287:281] !== '0)
                report_mismatch("tdata padding", data[287:281], '0);
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    stage_stats_scoreboard stats_sb;
    bit gaps_on = 1;
    bit stall_on = 1;
    int idle_cycles = 0;

    stage_latency_statistics_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic logic [TS_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TS_W-1:0];
    endfunction

    // Present one word, optionally after a gap, and hold it until accepted.
    task automatic drive_word(logic [1:0] kind, logic [ID_W-1:0] id, logic [TS_W-1:0] ts,
                              logic [3:0] rs);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, rs, ts, id};
        do @(posedge aclk); while (!s_tready);
        stats_sb.note_word(kind, id, ts, rs);
    endtask

    task automatic put_mark(logic [ID_W-1:0] id, logic [TS_W-1:0] ts);
        drive_word(KIND_MARK, id, ts, 4'($urandom));
    endtask

    task automatic put_read(logic [3:0] rs);
        drive_word(KIND_READ, 16'($urandom), rand48(), rs);
    endtask

    task automatic put_control(logic [1:0] kind);
        drive_word(kind, 16'($urandom), rand48(), 4'($urandom));
    endtask

    // Result side: ready drops in random bursts while stalls are enabled.
    initial begin
        forever begin
            if (stall_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            stats_sb.check_word(m_tuser, m_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL stage_latency_statistics_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [ID_W-1:0] pool [POOL_SIZE];
        logic [TS_W-1:0] cur_ts;
        logic [TS_W-1:0] step;
        logic [ID_W-1:0] id;
        int words_sent;
        int loop_pos;
        int loop_len;
        int pick;

        stats_sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, ignored kind, clear with nothing stored
        put_read(4'd0);
        put_read(4'd15);
        put_control(KIND_IGNORED);
        put_control(KIND_CLEAR);
        // first loop head starts the profile; second stage measures across the wrap
        put_mark(16'h0000, 48'hFFFF_FFFF_FFF0);
        put_mark(16'hFFFF, 48'h0000_0000_0010);
        put_mark(16'h0000, 48'h0000_0000_0020);
        put_mark(16'hFFFF, 48'h0000_0000_0020);
        // saturate the loop head latency three times so the square sum saturates
        put_mark(16'h0000, 48'h8000_0000_0000);
        put_mark(16'h0000, 48'h0000_0000_0000);
        put_mark(16'hFFFF, 48'h0000_FFFF_FFFF);
        put_mark(16'h0000, 48'h0001_0000_0000);
        put_read(4'd0);
        put_read(4'd1);
        put_read(4'd2);
        put_control(KIND_CLEAR);
        put_read(4'd0);
        // first sample after a clear sets both extremes
        put_mark(16'h0000, 48'h0001_0000_0005);
        put_read(4'd0);

        pool[0] = 16'h0000;
        pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            pool[i] = 16'($urandom);
        cur_ts = rand48();
        loop_pos = 0;
        loop_len = 3;
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            if (words_sent >= RANDOM_WORDS - QUIET_WORDS) begin
                gaps_on = 0;
                stall_on = 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    step = $urandom_range(0, 2000);
                else if (pick < 80)
                    step = $urandom_range(0, 200000);
                else if (pick < 90)
                    step = '0;
                else if (pick < 96)
                    step = $urandom;
                else
                    step = rand48();
                cur_ts = cur_ts + step;
                put_mark(pool[loop_pos], cur_ts);
                loop_pos++;
                // walk the loop in order; long loops push the table to full
                if (loop_pos >= loop_len) begin
                    loop_pos = 0;
                    loop_len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, POOL_SIZE)
                                                           : $urandom_range(1, 6);
                end
            end else if (pick < 84) begin
                put_read(4'($urandom));
            end else if (pick < 87) begin
                put_control(KIND_CLEAR);
            end else if (pick < 90) begin
                put_control(KIND_IGNORED);
            end else begin
                id = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                 : pool[$urandom_range(0, POOL_SIZE - 1)];
                put_mark(id, $urandom_range(0, 1) ? rand48() : cur_ts + $urandom_range(0, 500));
            end
            words_sent++;
        end
        s_tvalid <= 1'b0;

        while (stats_sb.pending_reports.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (stats_sb.errors == 0)
            $display("PASS stage_latency_statistics_top");
        else
            $display("FAIL stage_latency_statistics_top");
        $finish;
    end

endmodule
